@@ rtl/core/pbss_pkg.sv @@
// ----------------------------------------------------------------------------
// pbss_pkg: shared types for the paged byte string search
// Request kinds, fixed field widths and the control bundle that the top
// level broadcasts to the matcher chain.
// ----------------------------------------------------------------------------
package pbss_pkg;

  // Fixed field widths
  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NIDX_W = 8;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned LEN_W  = 9;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_GAP   = 2'd3
  } kind_e;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic              shift;     // data byte steps the prefix bits
    logic              clear;     // drop all partial matches
    logic              load;      // needle byte write
    logic [NIDX_W-1:0] load_idx;  // needle position for a write
    logic [BYTE_W-1:0] data;      // needle byte or memory byte
  } ctrl_t;

endpackage

@@ rtl/core/pbss_cell.sv @@
// ----------------------------------------------------------------------------
// pbss_cell: one needle position of the matcher chain
// Holds one needle byte and one prefix match bit; the bit is handed on to
// the next cell each time a data byte comes by.
// ----------------------------------------------------------------------------
module pbss_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned IDX_W = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbss_pkg::ctrl_t    ctrl_i,
  input  logic [IDX_W-1:0]   last_idx_i,
  input  logic               prev_bit_i,
  output logic               bit_o,
  output logic               hit_o
);
  import pbss_pkg::*;

  logic [BYTE_W-1:0] needle_q;
  logic              bit_q, bit_d;
  logic              match_new;
  logic              is_last;

  // needle byte, undefined until loaded
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && (int'(ctrl_i.load_idx) == IDX)) begin
      needle_q <= ctrl_i.data;
    end
  end

  assign match_new = prev_bit_i && (ctrl_i.data == needle_q);
  assign is_last   = (int'(last_idx_i) == IDX);

  // prefix bit update
  always_comb begin
    bit_d = bit_q;
    priority if (ctrl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctrl_i.shift) begin
      bit_d = match_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;
  // the cell at the last needle position reports a completed match
  assign hit_o = ctrl_i.shift && match_new && is_last;

endmodule

@@ rtl/core/pbss_chain.sv @@
// ----------------------------------------------------------------------------
// pbss_chain: row of matcher cells
// Cell i holds needle byte i; prefix bits ripple from cell to cell, one
// step per data byte. The hit flag comes from the cell at the last position.
// ----------------------------------------------------------------------------
module pbss_chain #(
  parameter int unsigned MAX_NEEDLE = 256,
  parameter int unsigned IDX_W      = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pbss_pkg::ctrl_t    ctrl_i,
  input  logic [IDX_W-1:0]   last_idx_i,
  output logic               hit_o
);
  import pbss_pkg::*;

  logic [MAX_NEEDLE-1:0] bits;
  logic [MAX_NEEDLE-1:0] hits;

  for (genvar i = 0; i < MAX_NEEDLE; i++) begin : g_cell
    logic prev_bit;
    // the first cell always starts a new partial match
    if (i == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_body
      assign prev_bit = bits[i-1];
    end

    pbss_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .last_idx_i (last_idx_i),
      .prev_bit_i (prev_bit),
      .bit_o      (bits[i]),
      .hit_o      (hits[i])
    );
  end

  // at most one cell is the last position
  assign hit_o = |hits;

endmodule

@@ rtl/core/paged_byte_string_search.sv @@
// ----------------------------------------------------------------------------
// paged_byte_string_search: streaming exact substring matcher
// Finds the first occurrence of a loaded needle in a stream of memory bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Write needle_length on cfg_we_i/cfg_wdata_i while idle, load the needle
//   bytes with load requests, then send a start request followed by data
//   and gap requests. Every request gives exactly one result.
//   Slave side: tuser = kind, tlast = end of range, tdata = needle index,
//   byte value, byte address. Master side: tdata = hit address, tuser =
//   hit now and match found, tlast = search done.
//   Each result is registered and appears in the cycle after its request;
//   one request is taken every cycle while results are taken, as each cell
//   of the chain updates in a single step: it compares the broadcast byte
//   with its needle byte and hands its prefix bit to the next cell.
//   Reset clears all prefix bits, the flags, the hit address and sets the
//   needle length to one; needle bytes stay undefined until loaded.
//   When the receiver stalls, the result waits in the output register and
//   s_axis_tready drops until it is taken.
// ----------------------------------------------------------------------------
module paged_byte_string_search #(
  parameter int unsigned MAX_NEEDLE = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: needle_length
  input  logic                      cfg_we_i,
  input  logic [pbss_pkg::LEN_W-1:0] cfg_wdata_i,
  // request stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [7:0] needle_index, [15:8] byte_value, [79:16] byte_address
  input  logic [79:0]               s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]                s_axis_tuser,
  input  logic                      s_axis_tlast,
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [63:0] hit_address
  output logic [63:0]               m_axis_tdata,
  // [0] hit_now, [1] match_found
  output logic [1:0]                m_axis_tuser,
  output logic                      m_axis_tlast
);
  import pbss_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_NEEDLE);
  localparam int unsigned CMP_W = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;

  // request fields
  kind_e             kind;
  logic [NIDX_W-1:0] in_idx;
  logic [BYTE_W-1:0] in_byte;
  logic [ADDR_W-1:0] in_addr;
  logic              in_last;
  logic              accept;

  assign kind    = kind_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[7:0];
  assign in_byte = s_axis_tdata[15:8];
  assign in_addr = s_axis_tdata[79:16];
  assign in_last = s_axis_tlast;

  // search state
  logic [IDX_W-1:0]  last_idx_q, last_idx_d;
  logic              found_q, found_d;
  logic              done_q, done_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              hit;
  ctrl_t             ctrl;

  // output register
  logic              out_valid_q;
  logic              out_hit_q;
  logic              out_found_q;
  logic              out_done_q;
  logic [ADDR_W-1:0] out_addr_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // needle length, clipped to 1..MAX_NEEDLE and kept as last position
  logic [CMP_W-1:0] len_ext;
  always_comb begin
    len_ext = CMP_W'(cfg_wdata_i);
    priority if (len_ext == '0) begin
      last_idx_d = '0;
    end else if (len_ext > CMP_W'(MAX_NEEDLE)) begin
      last_idx_d = IDX_W'(MAX_NEEDLE - 1);
    end else begin
      last_idx_d = IDX_W'(len_ext - CMP_W'(1));
    end
  end

  // chain control
  always_comb begin
    ctrl.shift    = 1'b0;
    ctrl.clear    = cfg_we_i;
    ctrl.load     = 1'b0;
    ctrl.load_idx = in_idx;
    ctrl.data     = in_byte;
    if (accept) begin
      unique case (kind)
        KIND_LOAD: begin
          ctrl.load  = 1'b1;
          ctrl.clear = 1'b1;
        end
        KIND_START: begin
          ctrl.clear = 1'b1;
        end
        KIND_DATA: begin
          ctrl.shift = !done_q;
        end
        KIND_GAP: begin
          if (!done_q) begin
            ctrl.clear = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // next search state
  always_comb begin
    found_d = found_q;
    done_d  = done_q;
    addr_d  = addr_q;
    if (accept) begin
      unique case (kind)
        KIND_LOAD: ;
        KIND_START: begin
          found_d = 1'b0;
          done_d  = 1'b0;
          addr_d  = '0;
        end
        KIND_DATA: begin
          if (!done_q) begin
            if (hit) begin
              found_d = 1'b1;
              done_d  = 1'b1;
              addr_d  = in_addr - ADDR_W'(last_idx_q);
            end
            if (in_last) begin
              done_d = 1'b1;
            end
          end
        end
        KIND_GAP: begin
          if (!done_q && in_last) begin
            done_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  pbss_chain #(
    .MAX_NEEDLE (MAX_NEEDLE),
    .IDX_W      (IDX_W)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .last_idx_i (last_idx_q),
    .hit_o      (hit)
  );

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idx_q <= '0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
      addr_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        last_idx_q <= last_idx_d;
      end
      found_q <= found_d;
      done_q  <= done_d;
      addr_q  <= addr_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_hit_q   <= ctrl.shift && hit;
      out_found_q <= found_d;
      out_done_q  <= done_d;
      out_addr_q  <= addr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = {out_found_q, out_hit_q};
  assign m_axis_tlast  = out_done_q;

endmodule
